// File: hdl/aqsi_pkg.sv
// Shared types, sizes and codes for the array queue with search and insert.
package aqsi_pkg;

    localparam int DEPTH   = 16;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int WORD_W  = 32;
    localparam int FIELD_W = 5;
    localparam int WIDE_W  = (CNT_W > FIELD_W) ? CNT_W : FIELD_W;
    localparam int CMP_W   = WIDE_W + 1;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;

    typedef enum logic [1:0] {
        REQ_ENQ = 2'd0,
        REQ_DEQ = 2'd1,
        REQ_LOC = 2'd2,
        REQ_INS = 2'd3
    } req_kind_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADPOS = 2'd3
    } status_t;

    typedef struct packed {
        req_kind_t                  kind;
        logic signed [WORD_W-1:0]   value;
        logic [FIELD_W-1:0]         position;
    } req_t;

    typedef struct packed {
        status_t                    status;
        logic signed [WORD_W-1:0]   data_out;
        logic [FIELD_W-1:0]         found_position;
        logic [FIELD_W-1:0]         entry_count;
    } res_t;

    typedef struct packed {
        logic                       wr_en;
        logic [ADDR_W-1:0]          wr_addr;
        logic [WORD_W-1:0]          wr_data;
        logic                       rd_en;
        logic [ADDR_W-1:0]          rd_addr;
    } ram_req_t;

    // Fit a count into a 5-bit result field, dropping any upper bits.
    function automatic logic [FIELD_W-1:0] to_field(input logic [CNT_W-1:0] c);
        logic [WIDE_W-1:0] w;
        w = WIDE_W'(c);
        return w[FIELD_W-1:0];
    endfunction

endpackage

// File: hdl/array_queue_search_insert.sv
// Top level of the array queue with search and insert: memory, sequencer, output register.
//
// This block keeps up to DEPTH (16) signed 32-bit words packed from the head
// and serves one request per item on the slave stream: enqueue at the tail,
// dequeue from the head, locate the first entry equal to a value, or insert a
// value at a 1-based position. Every request yields exactly one result item on
// the master stream carrying a status code, the dequeued word, the found
// position and the number of entries left. Enqueue, every rejected request
// (full, empty, bad position), a locate on an empty store and an insert at
// the tail go straight to the result state without a walk. Dequeue and
// locate walk the stored words, and insert the words from the slot to the
// tail, through the single read port of the entry memory, one word per
// cycle; locate stops early at the first match. A word that moves is
// written in the cycle after its read, so no entry is ever read and written at once.
// Requests are worked on one at a time; the next one is accepted as soon as
// the previous result has moved into the output register, even if the
// downstream side has not taken it yet.
module array_queue_search_insert
    import aqsi_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // value [31:0], position [36:32], zeros
    input  logic [1:0]            s_tuser,   // req_type [1:0]

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // data_out [31:0], found_position [36:32],
                                             // entry_count [41:37], zeros
    output logic [1:0]            m_tuser    // status [1:0]
);

    req_t               req;
    res_t               res;
    logic               res_valid;
    logic               res_ready;
    ram_req_t           ram;
    logic [WORD_W-1:0]  rd_data;

    logic               out_valid_reg, out_valid_next;
    res_t               out_reg, out_next;

    // Unpack the incoming item.
    assign req.kind     = req_kind_t'(s_tuser);
    assign req.value    = $signed(s_tdata[WORD_W-1:0]);
    assign req.position = s_tdata[WORD_W+FIELD_W-1:WORD_W];

    aqsi_ram #(
        .WIDTH (WORD_W),
        .WORDS (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram.wr_en),
        .wr_addr (ram.wr_addr),
        .wr_data (ram.wr_data),
        .rd_en   (ram.rd_en),
        .rd_addr (ram.rd_addr),
        .rd_data (rd_data)
    );

    aqsi_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram       (ram),
        .rd_data   (rd_data)
    );

    // The output register takes a new result whenever it is empty or being drained.
    assign res_ready = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = M_TDATA_W'({out_reg.entry_count, out_reg.found_position,
                                  out_reg.data_out});

endmodule

// File: hdl/aqsi_ram.sv
// Simple dual-port synchronous RAM with one write port and one registered read port.
module aqsi_ram #(
    parameter int WIDTH = 32,
    parameter int WORDS = 16
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((WORDS > 1) ? $clog2(WORDS) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((WORDS > 1) ? $clog2(WORDS) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [WORDS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: hdl/aqsi_seq.sv
// Request sequencer: walks the entry memory to dequeue, locate and insert.
module aqsi_seq
    import aqsi_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  req_t              req,
    output logic              res_valid,
    input  logic              res_ready,
    output res_t              res,
    output ram_req_t          ram,
    input  logic [WORD_W-1:0] rd_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } state_t;

    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          occ_reg, occ_next;
    req_kind_t                 kind_reg, kind_next;
    logic [WORD_W-1:0]         value_reg, value_next;
    logic [ADDR_W-1:0]         ins_reg, ins_next;
    logic [ADDR_W-1:0]         idx_reg, idx_next;
    logic [CNT_W-1:0]          rem_reg, rem_next;
    logic                      pend_reg, pend_next;
    logic [ADDR_W-1:0]         src_reg, src_next;
    status_t                   status_reg, status_next;
    logic [WORD_W-1:0]         data_reg, data_next;
    logic [FIELD_W-1:0]        found_reg, found_next;

    logic                      full;
    logic [CMP_W-1:0]          pos_w;
    logic [CMP_W-1:0]          pos_m1;
    logic [CNT_W-1:0]          occ_m1;
    logic                      issue;

    assign full   = (occ_reg == CNT_W'(DEPTH));
    assign pos_w  = CMP_W'(req.position);
    assign pos_m1 = pos_w - CMP_W'(1);
    assign occ_m1 = occ_reg - CNT_W'(1);
    assign issue  = (state_reg == S_RUN) && (rem_reg != '0);

    always_comb
    begin
        state_next  = state_reg;
        occ_next    = occ_reg;
        kind_next   = kind_reg;
        value_next  = value_reg;
        ins_next    = ins_reg;
        idx_next    = idx_reg;
        rem_next    = rem_reg;
        pend_next   = 1'b0;
        src_next    = src_reg;
        status_next = status_reg;
        data_next   = data_reg;
        found_next  = found_reg;
        ram         = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    kind_next   = req.kind;
                    value_next  = $unsigned(req.value);
                    status_next = ST_OK;
                    data_next   = '0;
                    found_next  = '0;
                    idx_next    = '0;
                    rem_next    = occ_reg;
                    state_next  = S_DONE;
                    case (req.kind)
                        REQ_ENQ:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                ram.wr_en   = 1'b1;
                                ram.wr_addr = occ_reg[ADDR_W-1:0];
                                ram.wr_data = $unsigned(req.value);
                                occ_next    = occ_reg + CNT_W'(1);
                            end
                        end
                        REQ_DEQ:
                        begin
                            if (occ_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_RUN;
                            end
                        end
                        REQ_LOC:
                        begin
                            if (occ_reg != '0)
                            begin
                                state_next = S_RUN;
                            end
                        end
                        REQ_INS:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else if ((pos_w == '0) ||
                                     (pos_w > CMP_W'(occ_reg) + CMP_W'(1)))
                            begin
                                status_next = ST_BADPOS;
                            end
                            else
                            begin
                                // Shift entries from the tail down to the slot, last first.
                                ins_next = pos_m1[ADDR_W-1:0];
                                idx_next = occ_m1[ADDR_W-1:0];
                                rem_next = occ_reg - CNT_W'(pos_m1[ADDR_W-1:0]);
                                if (occ_reg == CNT_W'(pos_m1[ADDR_W-1:0]))
                                begin
                                    ram.wr_en   = 1'b1;
                                    ram.wr_addr = pos_m1[ADDR_W-1:0];
                                    ram.wr_data = $unsigned(req.value);
                                    occ_next    = occ_reg + CNT_W'(1);
                                end
                                else
                                begin
                                    state_next = S_RUN;
                                end
                            end
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end

            S_RUN:
            begin
                if (issue)
                begin
                    ram.rd_en = 1'b1;
                    ram.rd_addr = idx_reg;
                    rem_next  = rem_reg - CNT_W'(1);
                    idx_next  = (kind_reg == REQ_INS) ? idx_reg - ADDR_W'(1)
                                                      : idx_reg + ADDR_W'(1);
                    pend_next = 1'b1;
                    src_next  = idx_reg;
                end

                if (pend_reg)
                begin
                    case (kind_reg)
                        REQ_DEQ:
                        begin
                            if (src_reg == '0)
                            begin
                                data_next = rd_data;
                            end
                            else
                            begin
                                ram.wr_en   = 1'b1;
                                ram.wr_addr = src_reg - ADDR_W'(1);
                                ram.wr_data = rd_data;
                            end
                        end
                        REQ_LOC:
                        begin
                            if (rd_data == value_reg)
                            begin
                                found_next = to_field(CNT_W'(src_reg) + CNT_W'(1));
                                pend_next  = 1'b0;
                                state_next = S_DONE;
                            end
                        end
                        REQ_INS:
                        begin
                            ram.wr_en   = 1'b1;
                            ram.wr_addr = src_reg + ADDR_W'(1);
                            ram.wr_data = rd_data;
                        end
                        default:
                        begin
                            data_next = data_reg;
                        end
                    endcase
                end
                else if (!issue)
                begin
                    state_next = S_DONE;
                    case (kind_reg)
                        REQ_DEQ:
                        begin
                            occ_next = occ_m1;
                        end
                        REQ_INS:
                        begin
                            ram.wr_en   = 1'b1;
                            ram.wr_addr = ins_reg;
                            ram.wr_data = value_reg;
                            occ_next    = occ_reg + CNT_W'(1);
                        end
                        default:
                        begin
                            occ_next = occ_reg;
                        end
                    endcase
                end
            end

            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            occ_reg    <= '0;
            pend_reg   <= 1'b0;
            rem_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            occ_reg    <= occ_next;
            pend_reg   <= pend_next;
            rem_reg    <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        value_reg  <= value_next;
        ins_reg    <= ins_next;
        idx_reg    <= idx_next;
        src_reg    <= src_next;
        status_reg <= status_next;
        data_reg   <= data_next;
        found_reg  <= found_next;
    end

    assign req_ready          = (state_reg == S_IDLE);
    assign res_valid          = (state_reg == S_DONE);
    assign res.status         = status_reg;
    assign res.data_out       = $signed(data_reg);
    assign res.found_position = found_reg;
    assign res.entry_count    = to_field(occ_reg);

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CNT_W'(DEPTH))
        else $error("occupancy beyond depth");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (ram.wr_en && ram.rd_en) |-> (ram.wr_addr != ram.rd_addr))
        else $error("read and write of one entry in the same cycle");

    a_pend_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == S_RUN))
        else $error("read data pending outside the walk");

    a_occ_step: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_reg != $past(occ_reg)) |-> (state_reg == S_DONE))
        else $error("occupancy changed without finishing a request");

endmodule

// File: bench/array_queue_search_insert_tb.sv
// Self-checking bench for the array queue with search and insert, with random stream stalls.
module array_queue_search_insert_tb;
    import aqsi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // The run is stopped as a failure if it is still going after this many cycles.
    localparam int CYCLE_LIMIT = 200_000;
    // Cycles to keep watching the result stream once every expected item is in.
    localparam int SETTLE_CYCLES = DEPTH + 24;
    // Only the first few mismatches are printed; all of them are counted.
    localparam int PRINT_CAP = 20;
    localparam int RANDOM_ITEMS = 750;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;   // value [31:0], position [36:32], zeros
    logic [1:0]            s_tuser = REQ_ENQ;  // req_type [1:0]
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;   // data_out [31:0], found_position [36:32],
                                      // entry_count [41:37], zeros
    logic [1:0]            m_tuser;   // status [1:0]

    // One request waiting to be sent, with the pause the sender takes after it
    // and a flag that holds it back until every earlier result has come.
    typedef struct {
        req_kind_t                 kind;
        logic signed [WORD_W-1:0]  value;
        logic [FIELD_W-1:0]        position;
        int                        gap;
        bit                        drain;
    } request_t;

    // What one result item should carry.
    typedef struct {
        status_t                   status;
        logic signed [WORD_W-1:0]  data;
        logic [FIELD_W-1:0]        found;
        logic [FIELD_W-1:0]        count;
    } outcome_t;

    request_t  request_backlog[$];
    outcome_t  awaited_replies[$];

    // Mirror of the block's contents, kept packed from the head.
    logic signed [WORD_W-1:0]  store_words[DEPTH];
    int                        store_fill = 0;

    int accepted_cnt = 0;
    int results_cnt = 0;
    int err_count = 0;
    int cycle_cnt = 0;
    int send_wait = 0;
    int rx_wait = 0;
    bit rx_calm = 1'b0;

    array_queue_search_insert dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (err_count < PRINT_CAP)
        begin
            $display("ERROR %0t ns: %s: got %0h, expected %0h", $time, what, got, want);
        end
        err_count++;
    endtask

    // Applies one request to the mirror and returns the result it should give.
    // A full store is rejected before the position of an insert is looked at,
    // and a locate reports the first entry that matches.
    function automatic outcome_t apply_request(input req_kind_t kind,
                                               input logic signed [WORD_W-1:0] v,
                                               input logic [FIELD_W-1:0] pos);
        outcome_t o;
        int       i;
        bit       hit;
        o.status = ST_OK;
        o.data = '0;
        o.found = '0;
        hit = 1'b0;
        case (kind)
            REQ_ENQ:
            begin
                if (store_fill >= DEPTH)
                begin
                    o.status = ST_FULL;
                end
                else
                begin
                    store_words[store_fill] = v;
                    store_fill++;
                end
            end
            REQ_DEQ:
            begin
                if (store_fill == 0)
                begin
                    o.status = ST_EMPTY;
                end
                else
                begin
                    o.data = store_words[0];
                    for (i = 0; i + 1 < store_fill; i++)
                    begin
                        store_words[i] = store_words[i + 1];
                    end
                    store_fill--;
                end
            end
            REQ_LOC:
            begin
                for (i = 0; i < store_fill; i++)
                begin
                    if (!hit && store_words[i] == v)
                    begin
                        o.found = FIELD_W'(i + 1);
                        hit = 1'b1;
                    end
                end
            end
            default:
            begin
                if (store_fill >= DEPTH)
                begin
                    o.status = ST_FULL;
                end
                else if (pos == 0 || int'(pos) > store_fill + 1)
                begin
                    o.status = ST_BADPOS;
                end
                else
                begin
                    for (i = store_fill; i >= int'(pos); i--)
                    begin
                        store_words[i] = store_words[i - 1];
                    end
                    store_words[pos - 1] = v;
                    store_fill++;
                end
            end
        endcase
        o.count = FIELD_W'(store_fill);
        return o;
    endfunction

    task automatic push_req(input req_kind_t k, input logic signed [WORD_W-1:0] v,
                            input logic [FIELD_W-1:0] p, input int g, input bit d);
        request_t r;
        r.kind = k;
        r.value = v;
        r.position = p;
        r.gap = g;
        r.drain = d;
        request_backlog.push_back(r);
    endtask

    // Sender. An item stays on the bus until it is taken; on acceptance the
    // mirror is updated and the expected result is queued. After each item the
    // sender idles for the gap drawn with it, and an item marked for draining
    // is held back until every result so far has been taken downstream.
    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        logic     busy;
        logic     took;
        logic     drained;
        request_t req;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= REQ_ENQ;
            send_wait = 0;
        end
        else
        begin
            busy = s_tvalid;
            took = s_tvalid && s_tready;
            if (took)
            begin
                awaited_replies.push_back(apply_request(req_kind_t'(s_tuser),
                                                        s_tdata[31:0], s_tdata[36:32]));
                accepted_cnt <= accepted_cnt + 1;
                busy = 1'b0;
            end
            drained = (results_cnt >= accepted_cnt + int'(took));
            if (!busy)
            begin
                if (send_wait != 0)
                begin
                    send_wait--;
                    s_tvalid <= 1'b0;
                end
                else if (request_backlog.size() != 0 &&
                         (!request_backlog[0].drain || drained))
                begin
                    req = request_backlog.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {3'b000, req.position, req.value};
                    s_tuser <= req.kind;
                    send_wait = req.gap;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver. Each taken result is compared field by field with the oldest
    // expectation. After every result a random stall is drawn, and
    // now and then the receiver switches into a stretch with no stalls at all.
    always @(posedge clk or negedge rst_n)
    begin : check_results
        outcome_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_wait = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (awaited_replies.size() == 0)
                begin
                    report_mismatch("result item with nothing expected", m_tdata[31:0], 0);
                end
                else
                begin
                    want = awaited_replies.pop_front();
                    if (m_tuser !== want.status)
                    begin
                        report_mismatch("status", m_tuser, want.status);
                    end
                    if (m_tdata[31:0] !== want.data)
                    begin
                        report_mismatch("data_out", m_tdata[31:0], want.data);
                    end
                    if (m_tdata[36:32] !== want.found)
                    begin
                        report_mismatch("found_position", m_tdata[36:32], want.found);
                    end
                    if (m_tdata[41:37] !== want.count)
                    begin
                        report_mismatch("entry_count", m_tdata[41:37], want.count);
                    end
                end
                results_cnt <= results_cnt + 1;
                if ($urandom_range(0, 40) == 0)
                begin
                    rx_calm = !rx_calm;
                end
                rx_wait = rx_calm ? 0 : $urandom_range(0, 14);
            end
            else if (rx_wait != 0)
            begin
                rx_wait--;
            end
            m_tready <= (rx_wait == 0);
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        logic signed [WORD_W-1:0] pool[6];
        req_kind_t                k;
        logic signed [WORD_W-1:0] v;
        logic [FIELD_W-1:0]       p;
        int                       made;
        int                       span;
        int                       mode;
        int                       r;
        bit                       quiet;
        bit                       hold;

        // Directed part: rejects on an empty store, inserts at the head, the
        // middle and the tail, a position one past the tail, locate hits and
        // misses with duplicates, then a full store where both enqueue and
        // insert must report full, even with a position that is also bad.
        push_req(REQ_DEQ, 32'sh1234_5678, 5'd31, 0, 1'b0);
        push_req(REQ_LOC, 32'sh0, 5'd0, 1, 1'b0);
        push_req(REQ_INS, 32'sh11, 5'd0, 0, 1'b0);
        push_req(REQ_INS, 32'sh22, 5'd2, 2, 1'b0);
        push_req(REQ_INS, 32'sh8000_0000, 5'd1, 0, 1'b0);
        push_req(REQ_ENQ, 32'sh7fff_ffff, 5'd31, 0, 1'b0);
        push_req(REQ_ENQ, -32'sd1, 5'd0, 3, 1'b0);
        push_req(REQ_INS, 32'sh0, 5'd2, 0, 1'b0);
        push_req(REQ_INS, 32'sh5, 5'd6, 0, 1'b0);
        push_req(REQ_INS, 32'sh1, 5'd5, 1, 1'b0);
        push_req(REQ_LOC, 32'sh7fff_ffff, 5'd9, 0, 1'b0);
        push_req(REQ_LOC, 32'sh0001_2345, 5'd0, 0, 1'b0);
        push_req(REQ_ENQ, 32'sh0, 5'd0, 0, 1'b0);
        push_req(REQ_LOC, 32'sh0, 5'd31, 0, 1'b0);
        push_req(REQ_DEQ, 32'sh0, 5'd0, 0, 1'b0);
        for (int i = 0; i < 11; i++)
        begin
            push_req(REQ_ENQ, $urandom, 5'(i), 0, 1'b0);
        end
        push_req(REQ_ENQ, 32'sh6, 5'd0, 0, 1'b0);
        push_req(REQ_INS, 32'sh7, 5'd0, 0, 1'b0);
        push_req(REQ_INS, 32'sh8, 5'd31, 0, 1'b0);
        push_req(REQ_DEQ, 32'sh0, 5'd0, 0, 1'b0);

        // Random part in phases that lean toward filling, emptying or neither,
        // so the store spends time both near full and near empty. Half the
        // values come from a small pool, which gives duplicates and locate hits.
        pool[0] = 32'sh8000_0000;
        pool[1] = 32'sh7fff_ffff;
        pool[2] = 32'sh0;
        pool[3] = -32'sd1;
        pool[4] = $urandom;
        pool[5] = $urandom;
        made = 0;
        while (made < RANDOM_ITEMS)
        begin
            span = $urandom_range(15, 60);
            mode = $urandom_range(0, 2);
            quiet = ($urandom_range(0, 3) == 0);
            hold = (made == 0) || ($urandom_range(0, 3) == 0);
            for (int i = 0; i < span && made < RANDOM_ITEMS; i++)
            begin
                r = $urandom_range(0, 99);
                case (mode)
                    0: k = (r < 45) ? REQ_ENQ : (r < 75) ? REQ_INS : (r < 87) ? REQ_LOC : REQ_DEQ;
                    1: k = (r < 15) ? REQ_ENQ : (r < 25) ? REQ_INS : (r < 45) ? REQ_LOC : REQ_DEQ;
                    default: k = req_kind_t'(r % 4);
                endcase
                v = $urandom_range(0, 1) ? pool[$urandom_range(0, 5)] : $urandom;
                p = ($urandom_range(0, 4) != 0) ? 5'($urandom_range(1, 17))
                                                : 5'($urandom_range(0, 31));
                push_req(k, v, p, quiet ? 0 : $urandom_range(0, 14), hold && i == 0);
                made++;
            end
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until every item has been sent and every expected result taken,
        // then keep watching a while for anything extra.
        while (request_backlog.size() != 0 || s_tvalid || results_cnt < accepted_cnt)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (awaited_replies.size() != 0)
        begin
            report_mismatch("expected result items never came", awaited_replies.size(), 0);
        end

        if (err_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
